// ----- src/lir_pkg.sv -----
`default_nettype none
package lir_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_W     = 32;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 4;
    localparam int STEP_W       = 20;
    localparam int POS_W        = FRAC_BITS + 5;
    localparam int PROD_W       = SAMPLE_W + FRAC_BITS + 2;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int BITS_PER_BYTE = 8;

    localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 3);

    localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = CNT_W'(2);
    localparam logic [1:0]        RST_WIDTH_MODE    = 2'd1;
    localparam logic [STEP_W-1:0] RST_SPEED_STEP    = STEP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT     = CFG_IDX_W'(0),
        CFG_SAMPLE_WIDTH_MODE = CFG_IDX_W'(1),
        CFG_SPEED_STEP        = CFG_IDX_W'(2)
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]    n;
        logic [SAMPLE_W-1:0] mask;
        logic [STEP_W-1:0]   step;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic store;
        logic retire;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic start_emit;
        logic pos_ge_one;
        logic out_free;
        logic run_last;
    } t_status;

    function automatic logic [CNT_W-1:0] active_channels(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n == '0) begin
            n = CNT_W'(1);
        end
        if (n > CNT_W'(MAX_CHANNELS)) begin
            n = CNT_W'(MAX_CHANNELS);
        end
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] width_mask(input logic [1:0] mode);
        logic [4:0] sh;
        sh = 5'(BITS_PER_BYTE) * {3'b000, 2'd3 - mode};
        return {SAMPLE_W{1'b1}} >> sh;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] step);
        return (step < MIN_STEP) ? MIN_STEP : step;
    endfunction

endpackage
`default_nettype wire

// ----- src/lir_in_if.sv -----
`default_nettype none
interface lir_in_if;
    import lir_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] in_sample;
    logic                buffer_start;

    modport source(output valid, output in_sample, output buffer_start, input ready);
    modport sink(input valid, input in_sample, input buffer_start, output ready);
endinterface
`default_nettype wire

// ----- src/lir_out_if.sv -----
`default_nettype none
interface lir_out_if;
    import lir_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] out_sample;
    logic [CH_W-1:0]     out_channel;
    logic                last_of_run;

    modport source(output valid, output out_sample, output out_channel, output last_of_run,
                   input ready);
    modport sink(input valid, input out_sample, input out_channel, input last_of_run,
                 output ready);
endinterface
`default_nettype wire

// ----- src/lir_cfg_if.sv -----
`default_nettype none
interface lir_cfg_if;
    import lir_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/linear_interp_resampler.sv -----
// Linear interpolation resampler.
// i_in   : sample requests, one channel word at a time, frames interleaved;
//          buffer_start restarts position, history and the channel counter.
// o_out  : interpolated samples with channel index; last_of_run marks the
//          final request caused by one input request.
// i_cfg  : register writes (index, data), ready out of reset; write only when idle.
// Flow   : an input request that does not complete a frame is stored from idle.
//          A completing request with history enters a check state, which
//          skips the frame if the position is past it; else each output
//          sample takes a multiply state and an output register load state,
//          up to 64 outputs per frame, on the single shared multiplier.
//          i_in is not ready while outputs are being produced.
// Stall  : while o_out is stalled the output register holds its request and
//          the next interpolation waits; nothing is lost.
// Reset  : synchronous, active low; registers return to 2 channels, 16-bit
//          samples, unity speed; history and position are cleared.
`default_nettype none
module linear_interp_resampler (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lir_cfg_if.sink   i_cfg,
    lir_in_if.sink    i_in,
    lir_out_if.source o_out
);
    import lir_pkg::*;

    logic [CNT_W-1:0]  r_channel_count;
    logic [1:0]        r_sample_width_mode;
    logic [STEP_W-1:0] r_speed_step;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count     <= RST_CHANNEL_COUNT;
            r_sample_width_mode <= RST_WIDTH_MODE;
            r_speed_step        <= RST_SPEED_STEP;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CHANNEL_COUNT:     r_channel_count     <= i_cfg.data[CNT_W-1:0];
                CFG_SAMPLE_WIDTH_MODE: r_sample_width_mode <= i_cfg.data[1:0];
                CFG_SPEED_STEP:        r_speed_step        <= i_cfg.data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.n    = active_channels(r_channel_count);
    assign cfg.mask = width_mask(r_sample_width_mode);
    assign cfg.step = clamp_step(r_speed_step);

    assign i_in.ready = in_ready;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lir_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (i_in.in_sample),
        .i_buffer_start (i_in.buffer_start),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_sample   (o_out.out_sample),
        .o_out_channel  (o_out.out_channel),
        .o_out_last     (o_out.last_of_run)
    );

endmodule
`default_nettype wire

// ----- src/lir_ctrl.sv -----
`default_nettype none
module lir_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire lir_pkg::t_status i_status,
    output lir_pkg::t_cmd         o_cmd
);
    import lir_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_status.start_emit) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.pos_ge_one) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.run_last ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/lir_dp.sv -----
`default_nettype none
module lir_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lir_pkg::t_cfg          i_cfg,
    input  wire lir_pkg::t_cmd          i_cmd,
    output lir_pkg::t_status            o_status,
    input  wire logic [31:0]            i_sample,
    input  wire logic                   i_buffer_start,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [31:0]                 o_out_sample,
    output logic [2:0]                  o_out_channel,
    output logic                        o_out_last
);
    import lir_pkg::*;

    logic [SAMPLE_W-1:0] r_older [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_newer [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] n_newer [MAX_CHANNELS];
    logic [CH_W-1:0]     r_cnt;
    logic [CH_W-1:0]     r_ch;
    logic                r_have;
    logic [POS_W-1:0]    r_pos;

    logic signed [PROD_W-1:0] r_prod;
    logic [SAMPLE_W-1:0]      r_a;
    logic                     r_last;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [CH_W-1:0]     r_out_channel;
    logic                r_out_last;

    logic [SAMPLE_W-1:0]      sample_m;
    logic [CH_W-1:0]          cnt_eff;
    logic                     have_eff;
    logic                     frame_done;
    logic                     ch_last;
    logic [POS_W-1:0]         pos_next;
    logic signed [SAMPLE_W:0] diff;
    logic signed [FRAC_BITS:0] frac;
    logic [SAMPLE_W-1:0]      lerp_val;

    always_comb begin
        sample_m   = i_sample & i_cfg.mask;
        cnt_eff    = i_buffer_start ? '0 : r_cnt;
        have_eff   = r_have & ~i_buffer_start;
        frame_done = (CNT_W'(cnt_eff) + CNT_W'(1)) >= i_cfg.n;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            n_newer[i] = i_buffer_start ? '0 : r_newer[i];
            if (CH_W'(i) == cnt_eff) begin
                n_newer[i] = sample_m;
            end
        end
        ch_last  = (CNT_W'(r_ch) + CNT_W'(1)) >= i_cfg.n;
        pos_next = r_pos + POS_W'(i_cfg.step);
        diff     = $signed({1'b0, r_newer[r_ch]}) - $signed({1'b0, r_older[r_ch]});
        frac     = $signed({1'b0, r_pos[FRAC_BITS-1:0]});
        lerp_val = (r_a + r_prod[FRAC_BITS +: SAMPLE_W]) & i_cfg.mask;
    end

    assign o_status.start_emit = frame_done & have_eff;
    assign o_status.pos_ge_one = r_pos >= POS_ONE;
    assign o_status.out_free   = ~r_out_valid | i_out_ready;
    assign o_status.run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_older[i] <= '0;
                r_newer[i] <= '0;
            end
            r_cnt       <= '0;
            r_ch        <= '0;
            r_have      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_newer <= n_newer;
                r_ch    <= '0;
                r_cnt   <= frame_done ? '0 : cnt_eff + CH_W'(1);
                if (frame_done && !have_eff) begin
                    r_older <= n_newer;
                    r_have  <= 1'b1;
                end else if (i_buffer_start) begin
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        r_older[i] <= '0;
                    end
                    r_have <= 1'b0;
                end
                if (i_buffer_start) begin
                    r_pos <= '0;
                end
            end
            if (i_cmd.retire) begin
                r_pos   <= r_pos - POS_ONE;
                r_older <= r_newer;
                r_have  <= 1'b1;
            end
            if (i_cmd.emit) begin
                if (ch_last) begin
                    r_ch <= '0;
                    if (r_last) begin
                        r_pos   <= pos_next - POS_ONE;
                        r_older <= r_newer;
                        r_have  <= 1'b1;
                    end else begin
                        r_pos <= pos_next;
                    end
                end else begin
                    r_ch <= r_ch + CH_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(diff) * PROD_W'(frac);
            r_a    <= r_older[r_ch];
            r_last <= ch_last && (pos_next >= POS_ONE);
        end
        if (i_cmd.emit) begin
            r_out_sample  <= lerp_val;
            r_out_channel <= r_ch;
            r_out_last    <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_out_channel = r_out_channel;
    assign o_out_last    = r_out_last;

`ifndef ASSERT_OFF
    a_mul_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> (r_pos < POS_ONE))
        else $error("interpolation started with position beyond one frame");

    a_pos_needs_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_pos == '0))
        else $error("read position moved without a previous frame");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_last) |=> (r_have && (r_ch == '0) && r_out_valid && r_out_last))
        else $error("run did not close cleanly after its last request");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_linear_interp_resampler.sv -----
`default_nettype none
module tb_linear_interp_resampler;
    import lir_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int CALM_ITEMS    = 60;
    localparam int MAX_RUN       = 64;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_24 = 2'd2;
    localparam logic [1:0] WIDTH_32 = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     channel;
        logic                last;
    } t_sample_rec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lir_cfg_if cfg_ch ();
    lir_in_if  in_ch ();
    lir_out_if out_ch ();

    linear_interp_resampler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [CNT_W-1:0]    cfg_chans;
    logic [1:0]          cfg_width;
    logic [STEP_W-1:0]   cfg_step;
    logic [SAMPLE_W-1:0] prev_frame [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] cur_frame [MAX_CHANNELS];
    logic [CH_W-1:0]     fill_ch;
    logic                have_prev;
    logic [POS_W-1:0]    read_pos;

    t_sample_rec due_q [$];
    t_sample_rec want_rec;

    int errors      = 0;
    int cycles      = 0;
    int inputs_sent = 0;
    bit idling_on   = 1'b1;
    int stall_left  = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] width_bits(input logic [1:0] mode);
        case (mode)
            WIDTH_8:  return 32'h0000_00ff;
            WIDTH_16: return 32'h0000_ffff;
            WIDTH_24: return 32'h00ff_ffff;
            default:  return 32'hffff_ffff;
        endcase
    endfunction

    function automatic int chans_in_use();
        if (cfg_chans == '0) return 1;
        if (cfg_chans > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(cfg_chans);
    endfunction

    // floor(a + (b - a) * frac), signed span; low word of the floored product
    function automatic logic [SAMPLE_W-1:0] lerp_sample(input logic [SAMPLE_W-1:0] a,
                                                        input logic [SAMPLE_W-1:0] b,
                                                        input logic [FRAC_BITS-1:0] frac);
        longint span;
        longint scaled;
        span   = longint'(b) - longint'(a);
        scaled = span * longint'(frac);
        return a + scaled[SAMPLE_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

    function automatic void clear_history();
        int c;
        for (c = 0; c < MAX_CHANNELS; c++) begin
            prev_frame[c] = '0;
            cur_frame[c]  = '0;
        end
        fill_ch   = '0;
        have_prev = 1'b0;
        read_pos  = '0;
    endfunction

    function automatic void take_sample(input logic [SAMPLE_W-1:0] raw, input logic restart);
        logic [SAMPLE_W-1:0] mask;
        logic [STEP_W-1:0]   adv;
        t_sample_rec         rec;
        int                  n;
        int                  made;
        int                  c;
        mask = width_bits(cfg_width);
        n    = chans_in_use();
        made = 0;
        if (restart) begin
            clear_history();
        end
        cur_frame[fill_ch] = raw & mask;
        if (int'(fill_ch) + 1 < n) begin
            fill_ch = fill_ch + 1'b1;
            return;
        end
        fill_ch = '0;
        if (have_prev) begin
            adv = (cfg_step < MIN_STEP) ? MIN_STEP : cfg_step;
            while (read_pos < POS_ONE && made + n <= MAX_RUN) begin
                for (c = 0; c < n; c++) begin
                    rec.sample  = lerp_sample(prev_frame[c], cur_frame[c],
                                              read_pos[FRAC_BITS-1:0]) & mask;
                    rec.channel = CH_W'(c);
                    rec.last    = 1'b0;
                    due_q.insert(due_q.size(), rec);
                    made++;
                end
                read_pos = read_pos + POS_W'(adv);
            end
            if (read_pos >= POS_ONE) begin
                read_pos = read_pos - POS_ONE;
            end
            if (made > 0) begin
                rec      = due_q.pop_back();
                rec.last = 1'b1;
                due_q.insert(due_q.size(), rec);
            end
        end
        for (c = 0; c < MAX_CHANNELS; c++) begin
            prev_frame[c] = cur_frame[c];
        end
        have_prev = 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_CHANNEL_COUNT:     cfg_chans = val[CNT_W-1:0];
            CFG_SAMPLE_WIDTH_MODE: cfg_width = val[1:0];
            CFG_SPEED_STEP:        cfg_step  = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] word, input logic restart);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.in_sample    = word;
        in_ch.buffer_start = restart;
        do @(posedge i_clk); while (!in_ch.ready);
        take_sample(word, restart);
        inputs_sent++;
    endtask

    // drop the request line, wait for every due output, then let the block go idle
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_q.size() == 0) begin
                report_mismatch("unexpected output", out_ch.out_sample, '0);
            end else begin
                want_rec = due_q.pop_front();
                if (out_ch.out_sample !== want_rec.sample)
                    report_mismatch("out_sample", out_ch.out_sample, want_rec.sample);
                if (out_ch.out_channel !== want_rec.channel)
                    report_mismatch("out_channel", SAMPLE_W'(out_ch.out_channel),
                                    SAMPLE_W'(want_rec.channel));
                if (out_ch.last_of_run !== want_rec.last)
                    report_mismatch("last_of_run", SAMPLE_W'(out_ch.last_of_run),
                                    SAMPLE_W'(want_rec.last));
            end
        end
    end

    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 7);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    task automatic test_default_setup();
        send_sample(32'hffff_ffff, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        settle();
    endtask

    // zero channels acts as one; step below the floor gives 8 outputs per frame
    task automatic test_single_channel_slow();
        write_reg(CFG_CHANNEL_COUNT, 32'd0);
        write_reg(CFG_SAMPLE_WIDTH_MODE, CFG_DATA_W'(WIDTH_32));
        write_reg(CFG_SPEED_STEP, 32'd0);
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h8000_0001, 1'b0);
        settle();
    endtask

    task automatic test_widest_frame();
        int k;
        write_reg(CFG_CHANNEL_COUNT, 32'd15);
        write_reg(CFG_SAMPLE_WIDTH_MODE, CFG_DATA_W'(WIDTH_8));
        write_reg(CFG_SPEED_STEP, CFG_DATA_W'(MIN_STEP) - 1);
        for (k = 0; k < 2 * MAX_CHANNELS; k++) begin
            send_sample((k % 2 == 0) ? 32'hffff_ffff : random_word(), k == 0);
        end
        settle();
    endtask

    // shrink the frame while part of one is held; then run far past a frame
    task automatic test_shrink_midframe();
        write_reg(CFG_CHANNEL_COUNT, 32'd3);
        write_reg(CFG_SAMPLE_WIDTH_MODE, CFG_DATA_W'(WIDTH_24));
        write_reg(CFG_SPEED_STEP, 32'h000f_ffff);
        send_sample(32'h00ff_ffff, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0012_3456, 1'b0);
        send_sample(32'hff00_0000, 1'b0);
        send_sample(32'h00ff_ffff, 1'b0);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 32'd1);
        send_sample(32'h0080_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        settle();
    endtask

    task automatic test_random_streams();
        int  base;
        int  phase_len;
        int  frames_left;
        bit  restart;
        logic [CFG_DATA_W-1:0] step_val;
        base        = inputs_sent;
        frames_left = 0;
        while (inputs_sent - base < RANDOM_ITEMS) begin
            settle();
            if (inputs_sent - base >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
            write_reg(CFG_CHANNEL_COUNT, ($urandom_range(0, 4) == 0) ?
                      $urandom_range(0, 15) : $urandom_range(1, MAX_CHANNELS));
            write_reg(CFG_SAMPLE_WIDTH_MODE, $urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       step_val = $urandom_range(0, 8191);
                1:       step_val = $urandom_range(262144, 1048575);
                2:       step_val = 32'd65536;
                default: step_val = $urandom_range(8192, 131072);
            endcase
            write_reg(CFG_SPEED_STEP, step_val);
            phase_len = $urandom_range(20, 45);
            repeat (phase_len) begin
                restart = 1'b0;
                if (fill_ch == '0 && frames_left == 0) begin
                    restart     = 1'b1;
                    frames_left = $urandom_range(2, 12);
                end else if ($urandom_range(0, 29) == 0) begin
                    restart = 1'b1;
                end
                send_sample(random_word(), restart);
                if (fill_ch == '0 && frames_left > 0) frames_left--;
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_CHANNEL_COUNT;
        cfg_ch.data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.in_sample    = '0;
        in_ch.buffer_start = 1'b0;
        cfg_chans          = RST_CHANNEL_COUNT;
        cfg_width          = RST_WIDTH_MODE;
        cfg_step           = RST_SPEED_STEP;
        clear_history();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_setup();
        test_single_channel_slow();
        test_widest_frame();
        test_shrink_midframe();
        test_random_streams();
        settle();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
src/lir_pkg.sv
src/lir_in_if.sv
src/lir_out_if.sv
src/lir_cfg_if.sv
src/lir_ctrl.sv
src/lir_dp.sv
src/linear_interp_resampler.sv
tb/sv/tb_linear_interp_resampler.sv
